/* rtl/bmw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bmw_pkg;

  // widths fixed by the register map and the beat formats
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned MASK_W = 9;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned OUT_W  = 10;

  localparam logic [PIX_W-1:0]  FG_LEVEL     = 8'hFF;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;

  typedef enum logic [IDX_W-1:0] {
    CFG_MASK   = 2'd0,
    CFG_OP     = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_ERODE  = 1'b0,
    OP_DILATE = 1'b1
  } op_e;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    op_e               op;
  } morph_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic             foreground;
    logic [OUT_W-1:0] out_row;
    logic [OUT_W-1:0] out_col;
    logic             frame_done;
  } result_t;

endpackage

`default_nettype wire

/* rtl/bmw_line_store.sv */
`timescale 1ns / 1ps
`default_nettype none

// One entry per column; bit u holds line u of the stored rows.
module bmw_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 2,
  parameter int unsigned AW    = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* rtl/bmw_window.sv */
`timescale 1ns / 1ps
`default_nettype none

// Shift window and the erosion / dilation decision on its next contents.
module bmw_window #(
  parameter int unsigned KSIZE = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                advance_i,
  input  wire logic [KSIZE-1:0]    column_i,
  input  wire bmw_pkg::morph_cfg_t cfg_i,
  output logic                     fg_o
);

  localparam int unsigned KK = KSIZE * KSIZE;

  logic [KK-1:0] window_q;
  logic [KK-1:0] window_d;
  logic [KK-1:0] mask_full;

  // shift every row left, new column enters at the right
  always_comb begin
    for (int u = 0; u < KSIZE; u++) begin
      for (int v = 0; v < KSIZE - 1; v++) begin
        window_d[u*KSIZE+v] = window_q[u*KSIZE+v+1];
      end
      window_d[u*KSIZE+KSIZE-1] = column_i[u];
    end
  end

  assign mask_full = KK'(cfg_i.mask);

  always_comb begin
    unique case (cfg_i.op)
      bmw_pkg::OP_ERODE:  fg_o = &(window_d | ~mask_full);
      bmw_pkg::OP_DILATE: fg_o = |(window_d & mask_full);
      default:            fg_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (advance_i) begin
      window_q <= window_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/binary_morphology_window.sv */
`timescale 1ns / 1ps
`default_nettype none

// A pixel accepted at the input passes with its line store read into the window stage; the
//   window update then loads the output register, and a full, stalled output holds the stage.
// Throughput: one pixel per clock unless stalled; one line store read and write-back per beat.
// Reset clears counters, window, output valid and config (mask 0, erosion, 640 x 480).
// The line store is not cleared and takes no clearing pass; its rows fill as the frame runs.
module binary_morphology_window #(
  parameter int unsigned KSIZE      = 3,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // pixel input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire bmw_pkg::pixel_in_t          in_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output bmw_pkg::result_t                 out_o,
  // configuration writes
  input  wire logic                        cfg_we_i,
  input  wire logic [bmw_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire logic [bmw_pkg::CFG_W-1:0]   cfg_wdata_i
);

  localparam int unsigned HALF = KSIZE / 2;
  localparam int unsigned LW   = KSIZE - 1;            // stored rows
  localparam int unsigned CW   = $clog2(MAX_WIDTH);    // column counter / line store address
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);   // row counter
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  bmw_pkg::morph_cfg_t              cfg_q;
  logic [bmw_pkg::SIZE_W-1:0]       width_q;
  logic [bmw_pkg::SIZE_W-1:0]       height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask <= '0;
      cfg_q.op   <= bmw_pkg::OP_ERODE;
      width_q    <= bmw_pkg::WIDTH_RESET;
      height_q   <= bmw_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (bmw_pkg::cfg_idx_e'(cfg_index_i))
        bmw_pkg::CFG_MASK:   cfg_q.mask <= cfg_wdata_i[bmw_pkg::MASK_W-1:0];
        bmw_pkg::CFG_OP:     cfg_q.op   <= bmw_pkg::op_e'(cfg_wdata_i[0]);
        bmw_pkg::CFG_WIDTH:  width_q    <= cfg_wdata_i[bmw_pkg::SIZE_W-1:0];
        bmw_pkg::CFG_HEIGHT: height_q   <= cfg_wdata_i[bmw_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size to [KSIZE, MAX]
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (width_q < bmw_pkg::SIZE_W'(KSIZE)) begin
      w_eff = WW'(KSIZE);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q < bmw_pkg::SIZE_W'(KSIZE)) begin
      h_eff = HW'(KSIZE);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: raster counters and line store read
  // ---------------------------------------------------------------------------
  logic          in_acc;
  logic [RW-1:0] row_q, row_d, cur_row;
  logic [CW-1:0] col_q, col_d, cur_col;
  logic          col_last, row_last;

  assign in_acc = in_valid_i && !in_stall_o;

  // frame_start forces the beat to (0,0)
  assign cur_row  = in_i.frame_start ? '0 : row_q;
  assign cur_col  = in_i.frame_start ? '0 : col_q;
  assign col_last = (WW'(cur_col) + WW'(1)) >= w_eff;
  assign row_last = (HW'(cur_row) + HW'(1)) >= h_eff;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (in_acc) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : cur_row + RW'(1);
      end else begin
        col_d = cur_col + CW'(1);
        row_d = cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Window stage: line store data arrives, write back, decide
  // ---------------------------------------------------------------------------
  logic          s1_valid_q;
  logic [RW-1:0] s1_row_q;
  logic [CW-1:0] s1_col_q;
  logic          s1_pix_q;
  logic          s1_emit;
  logic          s1_done;
  logic          s1_adv;
  logic [LW-1:0] ls_rd_data;
  logic          fwd_q;
  logic [LW-1:0] fwd_data_q;
  logic [KSIZE-1:0] column;
  logic          win_fg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_row_q <= cur_row;
      s1_col_q <= cur_col;
      s1_pix_q <= (in_i.pixel_value == bmw_pkg::FG_LEVEL);
    end
  end

  // A read of the column written back in the same cycle (frame_start right after
  // a column 0 beat) returns the old entry: take the written bits instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= s1_adv && (cur_col == s1_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= column[KSIZE-1:1];
    end
  end

  // interior pixel whose window is complete
  assign s1_emit = (HW'(s1_row_q) < h_eff) && (WW'(s1_col_q) < w_eff) &&
                   (s1_row_q >= RW'(KSIZE - 1)) && (s1_col_q >= CW'(KSIZE - 1));
  assign s1_done = (HW'(s1_row_q) == h_eff - HW'(1)) && (WW'(s1_col_q) == w_eff - WW'(1));

  // advance unless a result must wait for a full, stalled output register
  assign s1_adv     = s1_valid_q && (!s1_emit || !out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;

  // newest row at the top of the column; stored rows move up by one line
  assign column = {s1_pix_q, (fwd_q ? fwd_data_q : ls_rd_data)};

  bmw_line_store #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (LW),
    .AW    (CW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (cur_col),
    .rd_data_o (ls_rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (column[KSIZE-1:1])
  );

  bmw_window #(
    .KSIZE (KSIZE)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s1_adv),
    .column_i  (column),
    .cfg_i     (cfg_q),
    .fg_o      (win_fg)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic             out_valid_q;
  bmw_pkg::result_t out_q;
  logic             out_load;

  assign out_load = s1_adv && s1_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.foreground <= win_fg;
      out_q.out_row    <= bmw_pkg::OUT_W'(s1_row_q - RW'(HALF));
      out_q.out_col    <= bmw_pkg::OUT_W'(s1_col_q - CW'(HALF));
      out_q.frame_done <= s1_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with no pixel in the window stage");

  a_blocked_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_col_q) && $stable(s1_row_q)))
    else $error("blocked window stage lost its pixel");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !out_load) |=> !out_valid_q)
    else $error("result beat repeated after it was taken");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (32'(col_q) < 32'(MAX_WIDTH)))
    else $error("column counter beyond line store depth");

endmodule

`default_nettype wire

/* dv/morph_checker.sv */
`timescale 1ns / 1ps

// Watches the pixel, result and register ports of the morphology window.
// Rebuilds the 3x3 window from the accepted pixel beats and compares each result beat.
module morph_checker import bmw_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_i,
  input  wire pixel_in_t           in_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_stall_i,
  input  wire result_t             out_i,
  input  wire logic                cfg_we_i,
  input  wire logic [IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_W-1:0]    cfg_wdata_i,
  output int                       err_count_o,
  output int                       pending_o,
  output int                       results_o
);

  localparam int unsigned WIN     = 3;
  localparam int unsigned LINE_SZ = 1024;

  logic [MASK_W-1:0] mask_q;
  op_e               op_q;
  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;

  bit                line_mem [WIN-1][LINE_SZ];
  logic [MASK_W-1:0] win_q;
  int unsigned       row_q;
  int unsigned       col_q;

  result_t           interior_q [$];
  result_t           want;
  int                errs;
  int                seen;

  function automatic int unsigned fit_size(input logic [SIZE_W-1:0] v, input int unsigned hi);
    if (v < WIN) return WIN;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic note_mismatch(input string what);
    if (errs < 100) $display("%0t ns: result mismatch: %s", $time, what);
    errs++;
  endtask

  // Shift one pixel into the window and queue the interior result it completes.
  task automatic shift_in_pixel(input pixel_in_t px);
    int unsigned       w;
    int unsigned       h;
    logic [WIN-1:0]    column;
    logic [MASK_W-1:0] nxt;
    logic [MASK_W-1:0] tested;
    result_t           r;
    w = fit_size(width_q, LINE_SZ);
    h = fit_size(height_q, LINE_SZ);
    if (px.frame_start) begin
      row_q = 0;
      col_q = 0;
    end
    column[WIN-1] = (px.pixel_value == FG_LEVEL);
    column[0]     = line_mem[0][col_q];
    column[1]     = line_mem[1][col_q];
    line_mem[0][col_q] = column[1];
    line_mem[1][col_q] = column[2];
    for (int u = 0; u < WIN; u++) begin
      for (int v = 0; v < WIN - 1; v++) nxt[u*WIN+v] = win_q[u*WIN+v+1];
      nxt[u*WIN+WIN-1] = column[u];
    end
    win_q = nxt;
    if (row_q < h && col_q < w && row_q >= WIN - 1 && col_q >= WIN - 1) begin
      tested       = win_q & mask_q;
      r.foreground = (op_q == OP_ERODE) ? (tested == mask_q) : (tested != '0);
      r.out_row    = OUT_W'(row_q - WIN / 2);
      r.out_col    = OUT_W'(col_q - WIN / 2);
      r.frame_done = (row_q == h - 1) && (col_q == w - 1);
      interior_q.push_back(r);
    end
    if (col_q + 1 >= w) begin
      col_q = 0;
      row_q = (row_q + 1 >= h) ? 0 : row_q + 1;
    end else begin
      col_q = col_q + 1;
    end
  endtask

  initial begin
    errs = 0;
    seen = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   = '0;
      op_q     = OP_ERODE;
      width_q  = WIDTH_RESET;
      height_q = HEIGHT_RESET;
      win_q    = '0;
      row_q    = 0;
      col_q    = 0;
      interior_q.delete();
    end else begin
      // results first: a beat leaving now belongs to an earlier pixel
      if (out_valid_i && !out_stall_i) begin
        seen++;
        if (interior_q.size() == 0) begin
          note_mismatch($sformatf("result beat %h with nothing expected", out_i));
        end else begin
          want = interior_q.pop_front();
          if (out_i.foreground !== want.foreground)
            note_mismatch($sformatf("foreground %b, expected %b at row %0d col %0d",
                                    out_i.foreground, want.foreground,
                                    want.out_row, want.out_col));
          if (out_i.out_row !== want.out_row)
            note_mismatch($sformatf("out_row %0d, expected %0d", out_i.out_row, want.out_row));
          if (out_i.out_col !== want.out_col)
            note_mismatch($sformatf("out_col %0d, expected %0d", out_i.out_col, want.out_col));
          if (out_i.frame_done !== want.frame_done)
            note_mismatch($sformatf("frame_done %b, expected %b at row %0d col %0d",
                                    out_i.frame_done, want.frame_done,
                                    want.out_row, want.out_col));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MASK:   mask_q   = cfg_wdata_i[MASK_W-1:0];
          CFG_OP:     op_q     = op_e'(cfg_wdata_i[0]);
          CFG_WIDTH:  width_q  = cfg_wdata_i[SIZE_W-1:0];
          CFG_HEIGHT: height_q = cfg_wdata_i[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) shift_in_pixel(in_i);
    end
    err_count_o <= errs;
    pending_o   <= interior_q.size();
    results_o   <= seen;
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import bmw_pkg::*;

  localparam int unsigned KSIZE       = 3;
  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MAX_HEIGHT  = 1024;
  // long output hold-off, in cycles, so the window backs up into the input
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_PIX  = 330;
  localparam int unsigned SETTLE_CYC  = 4;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  pixel_in_t            in_pix    = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  result_t              out_res;
  logic                 cfg_we    = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int                   err_count;
  int                   pending;
  int                   results;

  // stimulus bookkeeping
  bit                   calm         = 1'b0;
  int unsigned          fg_bias      = 55;
  int unsigned          eff_w        = 640;
  int unsigned          eff_h        = 480;
  int unsigned          pixels_sent  = 0;
  int unsigned          settings     = 0;
  int unsigned          hold_ticket  = 0;
  int unsigned          hold_served  = 0;

  always #5 clk = ~clk;

  binary_morphology_window #(
    .KSIZE      (KSIZE),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_pix),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  morph_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_i        (in_pix),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_i       (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .err_count_o (err_count),
    .pending_o   (pending),
    .results_o   (results)
  );

  // Gray level for one pixel: bias towards exactly 255, keep 254 close by so the
  // foreground compare is tested right at its edge, fill the rest at random.
  function automatic logic [PIX_W-1:0] pick_level();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < fg_bias) return FG_LEVEL;
    if (r < fg_bias + 8) return 8'hFE;
    return PIX_W'($urandom);
  endfunction

  // Frame size register value: mostly small frames, some below the window size
  // (clamped up), a few medium ones.
  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return SIZE_W'($urandom_range(0, 2));
    if (r < 15) return SIZE_W'($urandom_range(13, 24));
    return SIZE_W'($urandom_range(3, 12));
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return MASK_W'($urandom);
  endfunction

  // Drive one register for one cycle; the caller drops the write enable.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Program the whole register map. Spare data bits above the mask and the
  // operation bit carry noise, since the block must ignore them.
  task automatic program_regs(input logic [MASK_W-1:0] m, input op_e o,
                              input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    write_reg(CFG_MASK,   {2'($urandom_range(0, 3)), m});
    write_reg(CFG_OP,     {10'($urandom), o});
    write_reg(CFG_WIDTH,  w);
    write_reg(CFG_HEIGHT, h);
    cfg_we <= 1'b0;
    // track the clamped frame size to know where frames begin
    eff_w = (w < KSIZE) ? KSIZE : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    eff_h = (h < KSIZE) ? KSIZE : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
    settings++;
  endtask

  // Offer one pixel beat and hold it until the block takes it. A random idle
  // burst may come first unless the run is calm.
  task automatic send_pixel(input pixel_in_t px);
    if (!calm && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pix   <= px;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  // Stream pixels in raster order. With mark set, frame_start flags the first
  // pixel of the run and, mostly, the first pixel of each later frame; the rest
  // rely on the counters wrapping. With noise set, a stray frame_start may land
  // mid-frame.
  task automatic stream_pixels(input int unsigned count, input bit mark, input bit noise);
    int unsigned frame_len;
    pixel_in_t   px;
    frame_len = eff_w * eff_h;
    for (int unsigned i = 0; i < count; i++) begin
      px.pixel_value = pick_level();
      px.frame_start = mark && (i % frame_len == 0) &&
                       (i == 0 || $urandom_range(0, 99) < 70);
      if (noise && $urandom_range(0, 99) < 2) px.frame_start = 1'b1;
      send_pixel(px);
    end
  endtask

  // Drop valid and wait until every expected result beat has drained, then
  // let the window settle before the registers change.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Result side: random stall bursts, plus the long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_ticket != hold_served) begin
        hold_served = hold_ticket;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 15) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned          rand_start;
    int unsigned          count;
    int unsigned          budget;
    int unsigned          frame_len;
    bit                   hold_done;
    bit                   fresh;
    logic [SIZE_W-1:0]    w;
    pixel_in_t            px;

    hold_done = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full-mask erosion on a 3x3 frame with a 254 in the centre,
    // which must not count as foreground.
    program_regs('1, OP_ERODE, 11'd3, 11'd3);
    for (int i = 0; i < 9; i++) begin
      px.pixel_value = (i == 4) ? 8'hFE : FG_LEVEL;
      px.frame_start = (i == 0);
      send_pixel(px);
    end
    // Same frame size again without frame_start: the counters must wrap on
    // their own, and an all-255 window erodes to foreground.
    for (int i = 0; i < 9; i++) begin
      px.pixel_value = FG_LEVEL;
      px.frame_start = 1'b0;
      send_pixel(px);
    end
    settle();
    // Empty mask under dilation with sizes below the window: both clamp to 3,
    // and the result is background even with foreground in the window.
    program_regs('0, OP_DILATE, 11'd0, 11'd2);
    for (int i = 0; i < 9; i++) begin
      case (i % 3)
        0:       px.pixel_value = FG_LEVEL;
        1:       px.pixel_value = 8'h00;
        default: px.pixel_value = 8'h7F;
      endcase
      px.frame_start = (i == 0);
      send_pixel(px);
    end
    settle();

    // Height register far above the limit: clamped to the full height, so a
    // short stretch of a three-column frame runs without wrapping.
    fg_bias = 90;
    program_regs(pick_mask(), op_e'($urandom_range(0, 1)), 11'd3, 11'd2047);
    stream_pixels(30, 1'b1, 1'b0);
    settle();

    // Random phases: a new register setting each time, then whole frames with
    // random content; some phases stop mid-frame and the next may carry on
    // with a narrower width, so the counters wrap at the new limit.
    rand_start = pixels_sent;
    while (pixels_sent - rand_start < RANDOM_PIX) begin
      calm    = ($urandom_range(0, 3) == 0);
      fg_bias = ($urandom_range(0, 2) == 0) ? 25 : (($urandom_range(0, 1) == 0) ? 55 : 90);
      fresh   = ($urandom_range(0, 3) != 0);
      budget  = RANDOM_PIX - (pixels_sent - rand_start);
      if (fresh) begin
        if (!hold_done) begin
          // back up the result side while pixels keep coming; a 5 x 4 frame
          // gives several interior beats well inside the hold-off
          hold_done = 1'b1;
          program_regs(pick_mask(), op_e'($urandom_range(0, 1)), 11'd5, 11'd4);
          frame_len = eff_w * eff_h;
          count     = 3 * frame_len;
          hold_ticket++;
        end else begin
          program_regs(pick_mask(), op_e'($urandom_range(0, 1)), pick_size(), pick_size());
          frame_len = eff_w * eff_h;
          count     = frame_len * $urandom_range(1, 3);
          if ($urandom_range(0, 99) < 30) begin
            count = count - $urandom_range(1, frame_len - 1);
          end
        end
      end else begin
        // never widen mid-frame: the line store beyond the old width may hold
        // nothing yet
        w = ($urandom_range(0, 99) < 15) ? SIZE_W'($urandom_range(0, 2))
                                         : SIZE_W'($urandom_range(KSIZE, eff_w));
        program_regs(pick_mask(), op_e'($urandom_range(0, 1)), w, pick_size());
        count = $urandom_range(4, 2 * eff_w * eff_h);
      end
      if (count > budget) count = budget;
      stream_pixels(count, fresh, 1'b1);
      settle();
    end

    // Last stretch: no idling on either side.
    calm    = 1'b1;
    fg_bias = 55;
    program_regs(pick_mask(), op_e'($urandom_range(0, 1)), 11'd6, 11'd5);
    stream_pixels(2 * eff_w * eff_h, 1'b1, 1'b0);
    settle();
    repeat (8) @(posedge clk);

    $display("summary: %0d pixel beats over %0d register settings, %0d result beats checked",
             pixels_sent, settings, results);
    $display("summary: erosion and dilation, empty and full masks, clamped sizes, frame wrap,");
    $display("         mid-frame narrowing and a %0d-cycle result hold-off", HOLD_CYCLES);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bmw_pkg.sv
rtl/bmw_line_store.sv
rtl/bmw_window.sv
rtl/binary_morphology_window.sv
dv/morph_checker.sv
dv/tb_top.sv
